>>> src/rth_pkg.sv
// rth_pkg: shared types, constants and the arctangent threshold table
package rth_pkg;

	// channel order codes, any other code reads as rgb
	typedef enum logic [1:0] {
		ORDER_RGB = 2'd0,
		ORDER_BGR = 2'd1,
		ORDER_GRB = 2'd2
	} order_t;

	// im = ((g - b) * HUE_MUL) >>> HUE_SHIFT
	localparam logic signed [24:0] HUE_MUL   = 25'sd14529495;
	localparam int                 HUE_SHIFT = 24;
	localparam int                 PROD_W    = 34;

	// hue fold constants
	localparam logic [8:0] HUE_HALF = 9'd180;
	localparam logic [8:0] HUE_FULL = 9'd360;

	// saturation energy and root
	localparam int         SQRT_TABLE_SIZE = 65536;
	localparam int         SQRT_N_W        = $clog2(SQRT_TABLE_SIZE);
	localparam int         REM_W           = SQRT_N_W + 1;
	localparam int         ROOT_W          = 8;
	localparam logic [7:0] SAT_MAX         = 8'd255;

	// arctangent by binary search over tan((k + 0.5) deg), k = 0..89
	localparam int  DEG_STEPS = 90;
	localparam int  DEG_W     = 7;
	localparam int  TAN_FRAC  = 30;
	localparam int  TAN_W     = 37;
	localparam int  CMP_W     = 8 + TAN_W;
	localparam real TAN_ONE   = 2.0 ** TAN_FRAC;
	localparam real PI_R      = 3.14159265358979323846;

	typedef logic [TAN_W-1:0] tan_tab_t [DEG_STEPS];

	function automatic tan_tab_t build_tan_tab();
		tan_tab_t t;
		real      a;
		for (int k = 0; k < DEG_STEPS; k++) begin
			a    = real'(2 * k + 1) * PI_R / 360.0;
			t[k] = TAN_W'(longint'($tan(a) * TAN_ONE));
		end
		return t;
	endfunction

	localparam tan_tab_t TAN_THR = build_tan_tab();

	// word carried through the search stages
	typedef struct packed {
		logic [7:0]       ay;
		logic [7:0]       ax;
		logic [DEG_W-1:0] deg;
		logic             im_pos;
		logic             re_pos;
		logic             grey;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0] rem;
		logic [9:0]       lightness;
	} step_t;

endpackage

>>> src/rth_if.sv
// rth_if: valid/ready channels for pixel in, hls out and configuration
interface rth_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;
	logic [7:0] third_byte;

	modport source (output valid, first_byte, second_byte, third_byte, input ready);
	modport sink   (input valid, first_byte, second_byte, third_byte, output ready);
endinterface

interface rth_hls_if;
	logic       valid;
	logic       ready;
	logic [8:0] hue;
	logic [9:0] lightness;
	logic [7:0] saturation;

	modport source (output valid, hue, lightness, saturation, input ready);
	modport sink   (input valid, hue, lightness, saturation, output ready);
endinterface

interface rth_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> src/rgb_to_hls_pixel_converter.sv
// rgb_to_hls_pixel_converter: pipelined rgb to hue/lightness/saturation converter
//
//   channel   dir   word                                    handshake
//   cfg       in    data: channel order (2 bits)            valid/ready, ready always high
//   pixel     in    first_byte, second_byte, third_byte     valid/ready
//   hls       out   hue (9), lightness (10), saturation (8) valid/ready
//
// one pixel per clock sustained while hls does not stall; 13 register stages
// depth is set by the 8-step square root, run in lockstep with the 7-step atan search
// each stage has its own valid bit and loads when empty or when the next stage moves,
// so a stall at hls only holds the words behind it and bubbles still fill in
// arst_n clears the valid bits and the channel order (rgb); data registers are not reset
module rgb_to_hls_pixel_converter
	import rth_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rth_cfg_if.sink     cfg,
	rth_pix_if.sink     pixel,
	rth_hls_if.source   hls
);

	localparam int SQRT_STEPS = ROOT_W;
	localparam int NSTG       = 4 + SQRT_STEPS + 1;

	// configuration
	logic [1:0] channel_order_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_order_q <= ORDER_RGB;
		end else if (cfg.valid) begin
			channel_order_q <= cfg.data;
		end
	end

	// stage valid bits and load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;

	always_comb begin
		en[NSTG] = !vld_q[NSTG] || hls.ready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign pixel.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pixel.valid;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: channel mapping, re, g - b, lightness, r squared
	logic [7:0] r_c, g_c, b_c;
	logic [8:0] gb_sum;

	always_comb begin
		unique case (channel_order_q)
			ORDER_BGR: begin
				b_c = pixel.first_byte;
				g_c = pixel.second_byte;
				r_c = pixel.third_byte;
			end
			ORDER_GRB: begin
				g_c = pixel.first_byte;
				r_c = pixel.second_byte;
				b_c = pixel.third_byte;
			end
			default: begin
				r_c = pixel.first_byte;
				g_c = pixel.second_byte;
				b_c = pixel.third_byte;
			end
		endcase
		gb_sum = {1'b0, g_c} + {1'b0, b_c};
	end

	logic signed [9:0] re_s1;
	logic signed [8:0] dgb_s1;
	logic [9:0]        l_s1;
	logic [15:0]       rsq_s1;
	logic [7:0]        g_s1, b_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			re_s1  <= $signed({2'b00, r_c}) - $signed({2'b00, gb_sum[8:1]});
			dgb_s1 <= $signed({1'b0, g_c}) - $signed({1'b0, b_c});
			l_s1   <= {2'b00, r_c} + {2'b00, g_c} + {2'b00, b_c};
			rsq_s1 <= 16'(r_c) * 16'(r_c);
			g_s1   <= g_c;
			b_s1   <= b_c;
		end
	end

	// stage 2: hue product, partial sum of squares
	logic signed [PROD_W-1:0] prod_s2;
	logic [16:0]              sq_s2;
	logic signed [9:0]        re_s2;
	logic [9:0]               l_s2;
	logic [7:0]               b_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_s2 <= PROD_W'(dgb_s1) * PROD_W'(HUE_MUL);
			sq_s2   <= 17'(rsq_s1) + 17'(g_s1) * 17'(g_s1);
			re_s2   <= re_s1;
			l_s2    <= l_s1;
			b_s2    <= b_s1;
		end
	end

	// stage 3: floor shift gives im, full sum of squares, lightness squared
	logic signed [9:0] im_s3;
	logic signed [9:0] re_s3;
	logic [17:0]       sq_s3;
	logic [19:0]       lsq_s3;
	logic [9:0]        l_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			im_s3  <= prod_s2[PROD_W-1:HUE_SHIFT];
			re_s3  <= re_s2;
			sq_s3  <= 18'(sq_s2) + 18'(b_s2) * 18'(b_s2);
			lsq_s3 <= 20'(l_s2) * 20'(l_s2);
			l_s3   <= l_s2;
		end
	end

	// stage 4: magnitudes, quadrant flags, chroma energy with table clamp
	logic [9:0]        re_abs, im_abs;
	logic [23:0]       lsq10;
	logic [18:0]       lsub;
	logic signed [19:0] energy;
	logic [SQRT_N_W-1:0] n_c;
	step_t             step_c;
	step_t             step_s4;

	always_comb begin
		re_abs = re_s3[9] ? 10'(-re_s3) : 10'(re_s3);
		im_abs = im_s3[9] ? 10'(-im_s3) : 10'(im_s3);
		lsq10  = (24'(lsq_s3) << 3) + (24'(lsq_s3) << 1);
		lsub   = lsq10[23:5];
		energy = $signed({2'b00, sq_s3}) - $signed({1'b0, lsub});
		if (energy[19]) begin
			n_c = '0;
		end else if (energy[18:0] > 19'(SQRT_TABLE_SIZE - 1)) begin
			n_c = '1;
		end else begin
			n_c = energy[SQRT_N_W-1:0];
		end
		step_c.ay        = (im_abs > 10'd255) ? 8'hFF : im_abs[7:0];
		step_c.ax        = (re_abs > 10'd255) ? 8'hFF : re_abs[7:0];
		step_c.deg       = '0;
		step_c.im_pos    = (im_s3 > 0);
		step_c.re_pos    = (re_s3 > 0);
		step_c.grey      = (im_s3 == 0) && (re_s3 == 0);
		step_c.root      = '0;
		step_c.rem       = REM_W'(n_c);
		step_c.lightness = l_s3;
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			step_s4 <= step_c;
		end
	end

	// stages 5..12: one root bit per stage, and one atan bit in each of stages 5..11
	step_t stp_s [SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam int RBIT = SQRT_STEPS - 1 - j;
		localparam int DBIT = DEG_W - 1 - j;

		step_t            prv;
		step_t            nxt;
		logic [REM_W-1:0] trial;
		logic [DEG_W-1:0] cand;
		logic [DEG_W-1:0] idx;
		logic [CMP_W-1:0] lhs, rhs;

		if (j == 0) begin : g_first
			assign prv = step_s4;
		end else begin : g_next
			assign prv = stp_s[j-1];
		end

		always_comb begin
			nxt = prv;
			// digit-by-digit root, remainder kept as n - root^2
			trial = (REM_W'(prv.root) << (RBIT + 1)) + (REM_W'(1) << (2 * RBIT));
			if (prv.rem >= trial) begin
				nxt.rem  = prv.rem - trial;
				nxt.root = prv.root | (ROOT_W'(1) << RBIT);
			end
			// count of thresholds with ay/ax at or above tan((k + 0.5) deg)
			cand = '0;
			idx  = '0;
			lhs  = '0;
			rhs  = '0;
			if (DBIT >= 0) begin
				cand = prv.deg | (DEG_W'(1) << DBIT);
				idx  = (cand <= DEG_W'(DEG_STEPS)) ? cand - DEG_W'(1) : '0;
				lhs  = CMP_W'(prv.ay) << TAN_FRAC;
				rhs  = CMP_W'(prv.ax) * CMP_W'(TAN_THR[idx]);
				if ((cand <= DEG_W'(DEG_STEPS)) && (lhs >= rhs)) begin
					nxt.deg = cand;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[5+j]) begin
				stp_s[j] <= nxt;
			end
		end
	end

	// stage 13: quadrant fold, root rounding, output register
	step_t            last;
	logic [8:0]       hue_c;
	logic [8:0]       root_rnd;
	logic [8:0]       deg9;
	logic [8:0]       hue_s13;
	logic [9:0]       l_s13;
	logic [7:0]       sat_s13;

	always_comb begin
		last = stp_s[SQRT_STEPS-1];
		deg9 = 9'(last.deg);
		if (last.grey) begin
			hue_c = '0;
		end else if (last.im_pos) begin
			hue_c = last.re_pos ? deg9 : HUE_HALF - deg9;
		end else begin
			hue_c = last.re_pos ? HUE_FULL - deg9 : HUE_HALF + deg9;
		end
		// round to nearest: bump when the remainder passes the root
		root_rnd = 9'(last.root) + 9'(last.rem > REM_W'(last.root));
	end

	always_ff @(posedge clk) begin
		if (en[NSTG]) begin
			hue_s13 <= hue_c;
			l_s13   <= last.lightness;
			sat_s13 <= (root_rnd > 9'(SAT_MAX)) ? SAT_MAX : root_rnd[7:0];
		end
	end

	assign hls.valid      = vld_q[NSTG];
	assign hls.hue        = hue_s13;
	assign hls.lightness  = l_s13;
	assign hls.saturation = sat_s13;

	// a held result is never dropped by the stage enables
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG] && !hls.ready |=> vld_q[NSTG])
		else $error("held result word dropped");

	// black pixel gives zero hue and zero saturation
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		hls.valid && (hls.lightness == 10'd0) |-> (hls.hue == 9'd0) && (hls.saturation == 8'd0))
		else $error("black pixel with nonzero hue or saturation");

	// root recursion leaves remainder within 2 * root
	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] |-> (last.rem <= (REM_W'(last.root) << 1)))
		else $error("square root remainder out of range");

	// atan search never counts past the threshold table
	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NSTG-1] |-> (last.deg <= DEG_W'(DEG_STEPS)))
		else $error("atan degree count out of range");

	// a pixel accepted at the input marks the front stage valid next cycle
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		pixel.valid && pixel.ready |=> vld_q[1])
		else $error("accepted pixel lost at stage 1");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for the rgb to hls pixel converter
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rth_pkg::*;

	// the fourth channel order code, which the block reads as rgb
	localparam logic [1:0] ORDER_SPARE = 2'd3;

	// im scaling and the saturation root range
	localparam longint HUE_GAIN     = 64'sd14529495;
	localparam int     HUE_FRAC     = 24;
	localparam int     ENERGY_LIMIT = 65536;
	localparam int     CHAN_MAX     = 255;

	// timing: pipeline depth in register stages, run limits
	localparam int PIPE_LATENCY = 13;
	localparam int DRAIN_CYCLES = 4 * PIPE_LATENCY;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SEGMENTS     = 9;
	localparam int SEG_PIXELS   = 206;
	localparam int N_DIRECTED   = 21;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic [8:0] hue;
		logic [9:0] lightness;
		logic [7:0] saturation;
	} hls_word_t;

	// one directed pixel; typed rows carry their own expected word
	typedef struct packed {
		logic [1:0] order;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       typed;
		hls_word_t  want;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rth_cfg_if cfg_ch ();
	rth_pix_if pix_ch ();
	rth_hls_if hls_ch ();

	rgb_to_hls_pixel_converter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pixel  (pix_ch),
		.hls    (hls_ch)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// expected hls words in order of pixel acceptance
	hls_word_t expected_hls [$];

	// testbench copy of the channel order register
	logic [1:0] order_shadow = ORDER_RGB;

	// sin and cos of the rounding boundaries, (k + 0.5) degrees
	real bound_sin [90];
	real bound_cos [90];

	int error_count   = 0;
	int result_count  = 0;
	int cycle_count   = 0;
	int send_gap_pct  = 0;
	int recv_gap_pct  = 0;
	logic hold_trigger = 1'b0;
	logic hold_ready   = 1'b0;

	// directed pixels: extremes, every order, all four hue quadrants,
	// the grey case and the axis cases where hue lands on 90, 180, 270, 360
	pixel_row_t directed_rows [N_DIRECTED] = '{
		'{ORDER_RGB,   8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   10'd0,   8'd0}},
		'{ORDER_RGB,   8'd255, 8'd255, 8'd255, 1'b0, '0},
		'{ORDER_RGB,   8'd255, 8'd0,   8'd0,   1'b1, '{9'd360, 10'd255, 8'd211}},
		'{ORDER_RGB,   8'd0,   8'd255, 8'd0,   1'b0, '0},
		'{ORDER_RGB,   8'd0,   8'd0,   8'd255, 1'b0, '0},
		'{ORDER_RGB,   8'd255, 8'd255, 8'd0,   1'b0, '0},
		'{ORDER_RGB,   8'd255, 8'd0,   8'd255, 1'b0, '0},
		'{ORDER_RGB,   8'd0,   8'd255, 8'd255, 1'b0, '0},
		'{ORDER_RGB,   8'd128, 8'd255, 8'd1,   1'b0, '0},
		'{ORDER_RGB,   8'd128, 8'd1,   8'd255, 1'b0, '0},
		'{ORDER_RGB,   8'd100, 8'd100, 8'd100, 1'b0, '0},
		'{ORDER_RGB,   8'h55,  8'hAA,  8'h55,  1'b0, '0},
		'{ORDER_RGB,   8'hAA,  8'h55,  8'hAA,  1'b0, '0},
		'{ORDER_RGB,   8'd1,   8'd0,   8'd0,   1'b0, '0},
		'{ORDER_BGR,   8'd255, 8'd0,   8'd0,   1'b0, '0},
		'{ORDER_BGR,   8'd10,  8'd200, 8'd30,  1'b0, '0},
		'{ORDER_GRB,   8'd0,   8'd255, 8'd0,   1'b0, '0},
		'{ORDER_GRB,   8'd30,  8'd10,  8'd200, 1'b0, '0},
		'{ORDER_SPARE, 8'd255, 8'd0,   8'd0,   1'b1, '{9'd360, 10'd255, 8'd211}},
		'{ORDER_SPARE, 8'd200, 8'd30,  8'd10,  1'b0, '0},
		'{ORDER_RGB,   8'd0,   8'd0,   8'd0,   1'b1, '{9'd0,   10'd0,   8'd0}}
	};

	initial begin
		for (int k = 0; k < 90; k++) begin
			bound_sin[k] = $sin(real'(2 * k + 1) * 3.14159265358979323846 / 360.0);
			bound_cos[k] = $cos(real'(2 * k + 1) * 3.14159265358979323846 / 360.0);
		end
	end

	// rounded arctangent in degrees for a first-quadrant vector:
	// one degree for each boundary the angle reaches
	function automatic int quadrant_degrees(int y, int x);
		int deg;
		deg = 0;
		for (int k = 0; k < 90; k++)
			if (real'(y) * bound_cos[k] >= real'(x) * bound_sin[k])
				deg++;
		return deg;
	endfunction

	// square root rounded to nearest
	function automatic int rounded_root(int n);
		int r;
		r = 0;
		for (int bit_w = 1 << 10; bit_w != 0; bit_w = bit_w >> 1)
			if ((r + bit_w) * (r + bit_w) <= n)
				r += bit_w;
		if (n - r * r > r)
			r++;
		return r;
	endfunction

	// hue, lightness and saturation of one pixel under a channel order
	function automatic hls_word_t predict_hls(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [1:0] order);
		int     r, g, bl, re, im, ay, ax, hue, lsum, energy, sat;
		longint prod;
		hls_word_t w;
		case (order)
			ORDER_BGR: begin
				bl = b0; g = b1; r = b2;
			end
			ORDER_GRB: begin
				g = b0; r = b1; bl = b2;
			end
			default: begin
				r = b0; g = b1; bl = b2;
			end
		endcase
		re   = r - ((g + bl) >> 1);
		prod = longint'(g - bl) * HUE_GAIN;
		im   = int'(prod >>> HUE_FRAC);
		ay   = (im < 0) ? -im : im;
		ax   = (re < 0) ? -re : re;
		if (ay > CHAN_MAX) ay = CHAN_MAX;
		if (ax > CHAN_MAX) ax = CHAN_MAX;
		if (re == 0 && im == 0)
			hue = 0;
		else if (im > 0)
			hue = (re > 0) ? quadrant_degrees(ay, ax) : 180 - quadrant_degrees(ay, ax);
		else
			hue = (re > 0) ? 360 - quadrant_degrees(ay, ax) : 180 + quadrant_degrees(ay, ax);
		lsum   = r + g + bl;
		energy = r * r + g * g + bl * bl - ((lsum * lsum * 10) >> 5);
		if (energy < 0)
			sat = 0;
		else if (energy >= ENERGY_LIMIT)
			sat = rounded_root(ENERGY_LIMIT - 1);
		else
			sat = rounded_root(energy);
		if (sat > CHAN_MAX)
			sat = CHAN_MAX;
		w.hue        = 9'(hue);
		w.lightness  = 10'(lsum);
		w.saturation = 8'(sat);
		return w;
	endfunction

	task automatic report(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] ERROR: %s", $realtime, msg);
		error_count++;
	endtask

	// offer one pixel word, with random gaps in front, and queue its result
	// once accepted; valid is left high so the next word can follow directly
	task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input hls_word_t want);
		while ($urandom_range(99) < send_gap_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.first_byte  <= b0;
		pix_ch.second_byte <= b1;
		pix_ch.third_byte  <= b2;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
		expected_hls.push_back(want);
	endtask

	// channel order change: only once the pipeline has fully drained
	task automatic write_order(input logic [1:0] order);
		while (expected_hls.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= order;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		order_shadow = order;
	endtask

	// receiver: random stalls, forced low during the long hold-off
	always @(posedge clk) begin
		if (hold_ready)
			hls_ch.ready <= 1'b0;
		else
			hls_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// long receiver hold-off, counted here while the sender keeps offering,
	// so the pipeline fills and backs up into the pixel input
	initial begin
		wait (hold_trigger);
		@(posedge clk);
		hold_ready <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_ready <= 1'b0;
	end

	// result checker: each accepted hls word against the oldest expectation
	always @(posedge clk) begin
		hls_word_t want;
		if (arst_n && hls_ch.valid && hls_ch.ready) begin
			if (expected_hls.size() == 0) begin
				report($sformatf("unexpected hls word hue %0d lightness %0d saturation %0d",
					hls_ch.hue, hls_ch.lightness, hls_ch.saturation));
			end else begin
				want = expected_hls.pop_front();
				if (hls_ch.hue !== want.hue)
					report($sformatf("word %0d hue got %0d expected %0d",
						result_count, hls_ch.hue, want.hue));
				if (hls_ch.lightness !== want.lightness)
					report($sformatf("word %0d lightness got %0d expected %0d",
						result_count, hls_ch.lightness, want.lightness));
				if (hls_ch.saturation !== want.saturation)
					report($sformatf("word %0d saturation got %0d expected %0d",
						result_count, hls_ch.saturation, want.saturation));
			end
			result_count++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, expected_hls.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] pix [3];
		logic [7:0] base;
		logic [1:0] seg_order;
		hls_word_t  want;
		int         kind;

		// every cfg and pixel input starts at a known value
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = ORDER_RGB;
		pix_ch.valid       = 1'b0;
		pix_ch.first_byte  = 8'd0;
		pix_ch.second_byte = 8'd0;
		pix_ch.third_byte  = 8'd0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, under the first idling mix
		send_gap_pct = 38;
		recv_gap_pct = 78;
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].order != order_shadow) begin
				pix_ch.valid <= 1'b0;
				write_order(directed_rows[i].order);
			end
			want = directed_rows[i].typed ? directed_rows[i].want
				: predict_hls(directed_rows[i].b0, directed_rows[i].b1,
					directed_rows[i].b2, order_shadow);
			send_pixel(directed_rows[i].b0, directed_rows[i].b1, directed_rows[i].b2, want);
		end

		// random part: three idling mixes of three segments each, a channel order per segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: seg_order = ORDER_RGB;
				1: seg_order = ORDER_BGR;
				2: seg_order = ORDER_GRB;
				3: seg_order = ORDER_SPARE;
				4: seg_order = ORDER_GRB;
				5: seg_order = ORDER_BGR;
				6: seg_order = ORDER_RGB;
				7: seg_order = ORDER_GRB;
				default: seg_order = 2'($urandom_range(3));
			endcase
			pix_ch.valid <= 1'b0;
			write_order(seg_order);
			if (seg < 3) begin
				send_gap_pct = 38;
				recv_gap_pct = 78;
			end else if (seg < 6) begin
				send_gap_pct = 78;
				recv_gap_pct = 38;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			// start the long receiver stall with the first full-rate segment
			if (seg == 6)
				hold_trigger <= 1'b1;
			for (int n = 0; n < SEG_PIXELS; n++) begin
				kind = $urandom_range(9);
				base = 8'($urandom_range(255));
				for (int c = 0; c < 3; c++) begin
					case (kind)
						// grey pixels
						0: pix[c] = base;
						// corners of the colour cube
						1: pix[c] = $urandom_range(1) ? 8'd255 : 8'd0;
						// near grey: tiny re and im, axis and fold cases
						2: pix[c] = 8'(int'(base) + $urandom_range(6) - 3);
						default: pix[c] = 8'($urandom_range(255));
					endcase
				end
				send_pixel(pix[0], pix[1], pix[2],
					predict_hls(pix[0], pix[1], pix[2], order_shadow));
			end
		end
		pix_ch.valid <= 1'b0;

		// let the pipeline empty, then watch for strays
		while (expected_hls.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
